/* hdl/assert_macros.svh */
// Assertion macros for the RTL of the grayscale quantiser; only the top level includes them.
// Needs nothing else; each user includes it inside its module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

/* hdl/rgq_pkg.sv */
// Shared types, constants and the channel expansion table of the quantiser.
// Depends on nothing; imported by rgq_luma and the top level.
package rgq_pkg;

    localparam int PIXEL_W = 16;
    localparam int GRAY_W  = 8;
    localparam int MULT_W  = 32;
    localparam int SHIFT_W = 5;
    localparam int PROD_W  = GRAY_W + MULT_W;
    localparam int SUM_W   = 16;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    typedef logic [GRAY_W-1:0] gray_t;

    // Register indexes (paddr[3:2]).
    localparam logic [1:0] REG_SCALE_MULT  = 2'd0;
    localparam logic [1:0] REG_SCALE_SHIFT = 2'd1;
    localparam logic [1:0] REG_ZERO_POINT  = 2'd2;

    // Luma weights, in 1/256.
    localparam logic [7:0] W_RED   = 8'd77;
    localparam logic [7:0] W_GREEN = 8'd150;
    localparam logic [7:0] W_BLUE  = 8'd29;

    // c * 255 / 31, truncated, for a 5-bit channel.
    localparam logic [7:0] EXPAND5_LUT [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    // c * 255 / 63, truncated: 4c plus floor(c / 21).
    function automatic logic [7:0] expand6(input logic [5:0] c);
        logic [1:0] corr;
        corr = 2'((c >= 6'd21) ? 1 : 0) + 2'((c >= 6'd42) ? 1 : 0)
             + 2'((c == 6'd63) ? 1 : 0);
        return {c, 2'b00} + {6'd0, corr};
    endfunction

endpackage

/* hdl/rgb565_gray_int8_quantizer.sv */
// Top level: RGB565 pixel to 8-bit gray and signed 8-bit quantised level.
// Depends on rgq_pkg, rgq_luma and assert_macros.svh.
//
//  channel  | role            | payload (low bits first)
//  ---------+-----------------+------------------------------------------
//  s_*      | pixel items in  | tdata[15:0] pixel_word
//  m_*      | result items out| tdata[7:0] gray_level, [15:8] quantized_level
//  APB      | register port   | 0x0 scale_multiplier, 0x4 scale_shift,
//           |                 | 0x8 zero_point
//
// One item per cycle while m_tready is high, through four register stages:
// channel expansion, luma sum, 8x32 scale multiply, shift/offset/saturate.
// Each stage holds while the stage ahead is full and stalled, so a stall on
// m_tready backs up through the stages without loss; s_tready drops only
// once all four stages are full. Reset clears the valid bits and loads the
// registers with multiplier 1, shift 0 and zero point 0.
module rgb565_gray_int8_quantizer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [15:0]                  s_tdata,    // [15:0] pixel_word
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,    // [7:0] gray_level, [15:8] quantized_level
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rgq_pkg::ADDR_W-1:0]   paddr,
    input  logic [rgq_pkg::DATA_W-1:0]   pwdata,
    output logic [rgq_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import rgq_pkg::*;
    `include "assert_macros.svh"

    // Configuration registers
    logic [MULT_W-1:0]  scale_multiplier_reg;
    logic [SHIFT_W-1:0] scale_shift_reg;
    logic [7:0]         zero_point_reg;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_multiplier_reg <= MULT_W'(1);
            scale_shift_reg      <= '0;
            zero_point_reg       <= '0;
        end
        else if (cfg_write)
        begin
            // Unknown indexes and byte lanes within a word are ignored.
            unique case (paddr[3:2])
                REG_SCALE_MULT:  scale_multiplier_reg <= pwdata;
                REG_SCALE_SHIFT: scale_shift_reg      <= pwdata[SHIFT_W-1:0];
                REG_ZERO_POINT:  zero_point_reg       <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SCALE_MULT:  prdata = scale_multiplier_reg;
            REG_SCALE_SHIFT: prdata = {{(DATA_W-SHIFT_W){1'b0}}, scale_shift_reg};
            REG_ZERO_POINT:  prdata = {{(DATA_W-8){1'b0}}, zero_point_reg};
            default:         prdata = '0;
        endcase
    end

    // Luma stages
    logic  luma_valid;
    logic  luma_ready;
    gray_t luma_gray;

    rgq_luma u_luma (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .pixel     (s_tdata),
        .out_valid (luma_valid),
        .out_ready (luma_ready),
        .gray      (luma_gray)
    );

    // Scale multiply stage: keep gray alongside the exact 40-bit product
    logic              mul_valid_reg;
    logic [PROD_W-1:0] prod_reg;
    gray_t             mul_gray_reg;
    logic              out_ready_int;

    // Output stage
    logic              out_valid_reg;
    gray_t             out_gray_reg;
    logic [7:0]        out_quant_reg;

    assign out_ready_int = !out_valid_reg || m_tready;
    assign luma_ready    = !mul_valid_reg || out_ready_int;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else if (luma_ready)
        begin
            mul_valid_reg <= luma_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (luma_ready && luma_valid)
        begin
            prod_reg     <= {{MULT_W{1'b0}}, luma_gray} * {{GRAY_W{1'b0}}, scale_multiplier_reg};
            mul_gray_reg <= luma_gray;
        end
    end

    // Shift, add zero point, saturate to -128..127
    logic [PROD_W-1:0] shifted;
    logic              too_big;
    logic signed [9:0] offset_sum;
    logic [7:0]        quant_next;

    always_comb
    begin
        shifted    = prod_reg >> scale_shift_reg;
        too_big    = |shifted[PROD_W-1:8];
        offset_sum = $signed({2'b00, shifted[7:0]})
                   + $signed({{2{zero_point_reg[7]}}, zero_point_reg});
        priority if (too_big || offset_sum > 10'sd127)
        begin
            quant_next = 8'h7f;
        end
        else if (offset_sum < -10'sd128)
        begin
            quant_next = 8'h80;
        end
        else
        begin
            quant_next = offset_sum[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready_int)
        begin
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready_int && mul_valid_reg)
        begin
            out_gray_reg  <= mul_gray_reg;
            out_quant_reg <= quant_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_quant_reg, out_gray_reg};

    // A stalled multiply stage must hold its product.
    `ASSERT_CLK(a_mul_hold, clk, rst_n,
        mul_valid_reg && !out_ready_int |=> mul_valid_reg && $stable(prod_reg),
        "multiply stage lost or changed a stalled item")
    // Input back-pressure only when the output is full and stalled.
    `ASSERT_NEVER(a_ready_cause, clk, rst_n,
        !s_tready && !(m_tvalid && !m_tready),
        "s_tready low without a stalled output")
    // Zero gray gives a zero product, so the level is the zero point itself.
    `ASSERT_CLK(a_zero_gray, clk, rst_n,
        m_tvalid && m_tdata[7:0] == 8'd0 |-> m_tdata[15:8] == zero_point_reg,
        "zero gray did not quantise to the zero point")

endmodule

/* hdl/rgq_luma.sv */
// Two-stage luma pipe: channel expansion, then weighted sum down to 8 bits.
// Depends on rgq_pkg for widths, weights and the expansion table.
module rgq_luma (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rgq_pkg::PIXEL_W-1:0]   pixel,
    output logic                          out_valid,
    input  logic                          out_ready,
    output rgq_pkg::gray_t                gray
);
    import rgq_pkg::*;

    logic       exp_valid_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic       exp_ready;

    logic       gray_valid_reg;
    gray_t      gray_reg;
    logic [SUM_W-1:0] sum_next;

    assign exp_ready = !gray_valid_reg || out_ready;
    assign in_ready  = !exp_valid_reg || exp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            exp_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            red_reg   <= EXPAND5_LUT[pixel[15:11]];
            green_reg <= expand6(pixel[10:5]);
            blue_reg  <= EXPAND5_LUT[pixel[4:0]];
        end
    end

    always_comb
    begin
        sum_next = {8'd0, red_reg} * {8'd0, W_RED}
                 + {8'd0, green_reg} * {8'd0, W_GREEN}
                 + {8'd0, blue_reg} * {8'd0, W_BLUE};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gray_valid_reg <= 1'b0;
        end
        else if (exp_ready)
        begin
            gray_valid_reg <= exp_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exp_ready && exp_valid_reg)
        begin
            gray_reg <= sum_next[SUM_W-1:8];
        end
    end

    assign out_valid = gray_valid_reg;
    assign gray      = gray_reg;

endmodule
